// ===== src/framebuffer_pixel_alpha_blend_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the framebuffer pixel alpha blend block
// Clocked concurrent assertion wrappers used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_ALPHA_BLEND_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_ALPHA_BLEND_ASSERT_SVH

// Checked at every rising edge, quiet while reset is held.
`define FPAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FPAB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fpab_pkg.sv =====
// ---------------------------------------------------------------------------
// fpab_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fpab_pkg;

  localparam int unsigned SCREEN_W = 320;
  localparam int unsigned SCREEN_H = 240;
  localparam int unsigned DEPTH    = SCREEN_W * SCREEN_H;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned COV_W    = 8;
  localparam int unsigned CH_W     = 5;
  localparam int unsigned RED_POS  = 11;
  localparam int unsigned GREEN_POS = 6;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_BLEND = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic capture;   // latch the accepted input word
    logic calc;      // register address and screen check
    logic rd;        // issue the frame memory read
    logic mix;       // register the blended pixel
    logic wr;        // write the frame memory if the access calls for it
    logic load_out;  // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic needs_read;  // access in screen that needs the stored pixel
  } dp_stat_t;

endpackage

// ===== src/framebuffer_pixel_alpha_blend.sv =====
// ---------------------------------------------------------------------------
// framebuffer_pixel_alpha_blend
// 320x240 RGB555 framebuffer with write, read and coverage blend accesses.
// ---------------------------------------------------------------------------
// A write, refused, no-op or zero-coverage blend access steps through CALC, WR and
// FIN; a read or blend also steps through RD and MIX. FIN waits for a free output.
// One access at a time: a new word is accepted only once the last result is loaded,
// so each read-modify-write on the memory ends before the next access starts.
// Reset clears the controller and output valid; frame memory is not cleared.
module framebuffer_pixel_alpha_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode[1:0], pos_x[13:2], pos_y[25:14], pixel_value[41:26], coverage[49:42]
  input  logic [fpab_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[15:0], status[16]
  output logic [fpab_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fpab_pkg::*;

  `include "framebuffer_pixel_alpha_blend_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fpab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fpab_dp u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  `FPAB_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "double accept")
  `FPAB_ASSERT(a_refused_rd, out_tvalid && out_tdata[16] |-> out_tdata[15:0] == '0, "refused data")
  `FPAB_ASSERT_ALWAYS(a_load_when_free, cmd.load_out |-> (!out_tvalid || out_tready), "lost word")

endmodule

// ===== src/fpab_ctrl.sv =====
// ---------------------------------------------------------------------------
// fpab_ctrl
// Sequencer for one framebuffer access at a time and output valid tracking.
// ---------------------------------------------------------------------------
module fpab_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  fpab_pkg::dp_stat_t stat,
  output fpab_pkg::dp_cmd_t  cmd
);
  import fpab_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_MIX,
    ST_WR,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.capture  = (state_r == ST_IDLE) && in_tvalid;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = stat.needs_read ? ST_RD : ST_WR;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // The result waits here until the output register is free.
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/fpab_dp.sv =====
// ---------------------------------------------------------------------------
// fpab_dp
// Frame memory, address and screen check, channel blend and result register.
// ---------------------------------------------------------------------------
module fpab_dp (
  input  logic                             clk,
  input  logic [fpab_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic [fpab_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  fpab_pkg::dp_cmd_t                cmd,
  output fpab_pkg::dp_stat_t               stat
);
  import fpab_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [1:0]         op_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [PIX_W-1:0]   pix_r;
  logic [COV_W-1:0]   cov_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               inside_r;
  logic [PIX_W-1:0]   rdata_r;
  logic [PIX_W-1:0]   blend_r;
  logic [PIX_W-1:0]   rd_out_r;
  logic               status_r;

  logic               inside_c;
  logic               cov_nz;
  logic [23:0]        addr_full;
  logic [8:0]         inv_cov;
  logic [PIX_W-1:0]   blend_c;
  logic               we;

  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] o,
                                             input logic [CH_W-1:0] n,
                                             input logic [8:0]      inv,
                                             input logic [COV_W-1:0] c);
    logic [13:0] acc;
    acc = 14'(o) * 14'(inv) + 14'(n) * 14'(c);
    return acc[12:8];
  endfunction

  // Sign bit clear and below the screen size; the 13-bit compare keeps a
  // full-size screen correct.
  assign inside_c = !x_r[COORD_W-1] && ({1'b0, x_r} < 13'(SCREEN_W)) &&
                    !y_r[COORD_W-1] && ({1'b0, y_r} < 13'(SCREEN_H));
  assign cov_nz   = (cov_r != '0);
  assign stat.needs_read = inside_c &&
                           ((op_r == OP_READ) || ((op_r == OP_BLEND) && cov_nz));
  assign addr_full = 24'(y_r[COORD_W-2:0]) * 24'(SCREEN_W) + 24'(x_r[COORD_W-2:0]);

  assign inv_cov = 9'd256 - 9'(cov_r);
  assign blend_c = {mix_ch(rdata_r[RED_POS +: CH_W], pix_r[RED_POS +: CH_W],
                           inv_cov, cov_r),
                    mix_ch(rdata_r[GREEN_POS +: CH_W], pix_r[GREEN_POS +: CH_W],
                           inv_cov, cov_r),
                    1'b0,
                    mix_ch(rdata_r[CH_W-1:0], pix_r[CH_W-1:0], inv_cov, cov_r)};

  assign we = cmd.wr && inside_r &&
              ((op_r == OP_WRITE) || ((op_r == OP_BLEND) && cov_nz));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_tdata[1:0];
      x_r   <= in_tdata[13:2];
      y_r   <= in_tdata[25:14];
      pix_r <= in_tdata[41:26];
      cov_r <= in_tdata[49:42];
    end
    if (cmd.calc) begin
      addr_r   <= ADDR_W'(addr_full);
      inside_r <= inside_c;
    end
    if (cmd.mix) blend_r <= blend_c;
    if (cmd.load_out) begin
      rd_out_r <= (inside_r && (op_r == OP_READ)) ? rdata_r : '0;
      status_r <= !inside_r && (op_r != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata_r <= mem[addr_r];
    if (we) mem[addr_r] <= (op_r == OP_WRITE) ? pix_r : blend_r;
  end

  assign out_tdata = {7'b0, status_r, rd_out_r};

endmodule
